>>> sv/per_class_box_suppression_defines.svh
// ----------------------------------------------------------------------------
// per_class_box_suppression_defines: assertion macros
// Shared check shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_BOX_SUPPRESSION_DEFINES_SVH
`define PER_CLASS_BOX_SUPPRESSION_DEFINES_SVH

// same-cycle implication
`define PCBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcbs: same-cycle check failed");

// next-cycle implication
`define PCBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcbs: next-cycle check failed");

`endif

>>> sv/pcbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared constants and types for the per-class box suppression block.
// ----------------------------------------------------------------------------
package pcbs_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int MAX_OUT_DEF     = 64;
  localparam int COORD_BITS_DEF  = 16;

  localparam int IOU_LAT = 5;

  localparam logic [15:0] THRESH_RST   = 16'd29491;
  localparam logic [6:0]  MAX_KEPT_RST = 7'd64;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MAX_KEPT  = 2'd1;

  typedef struct packed {
    logic clr;
    logic shift;
  } ring_ctrl_t;

endpackage

>>> sv/pcbs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_cell
// One slot of the kept-box ring; takes its neighbor's box on each shift.
// ----------------------------------------------------------------------------
module pcbs_cell #(
  parameter int W = 72
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcbs_pkg::ring_ctrl_t   ctrl,
  input  logic                   nb_valid,
  input  logic [W-1:0]           nb_data,
  output logic                   valid,
  output logic [W-1:0]           data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clr) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_r <= nb_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

>>> sv/pcbs_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_iou
// Five-stage overlap test: inter * 2^16 > threshold * union.
// ----------------------------------------------------------------------------
module pcbs_iou #(
  parameter int CB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [CB-1:0] a_l, a_t, a_r, a_b,
  input  logic [CB-1:0] b_l, b_t, b_r, b_b,
  input  logic [15:0]   thresh,
  output logic          hit_v,
  output logic          hit
);

  localparam int PW = 2 * CB;

  logic [CB-1:0] x1, y1, x2, y2;
  logic [CB-1:0] iw_r, ih_r, wa_r, ha_r, wb_r, hb_r;
  logic          ov1_r, ov2_r, ov3_r, ov4_r;
  logic [PW-1:0] inter2_r, aa2_r, ab2_r, inter3_r;
  logic [PW:0]   uni3_r;
  logic [PW+15:0] lhs4_r;
  logic [PW+16:0] rhs4_r;
  logic          v1_r, v2_r, v3_r, v4_r, v5_r, hit_r;

  assign x1 = (a_l > b_l) ? a_l : b_l;
  assign y1 = (a_t > b_t) ? a_t : b_t;
  assign x2 = (a_r < b_r) ? a_r : b_r;
  assign y2 = (a_b < b_b) ? a_b : b_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: extents
    iw_r  <= x2 - x1;
    ih_r  <= y2 - y1;
    wa_r  <= a_r - a_l;
    ha_r  <= a_b - a_t;
    wb_r  <= b_r - b_l;
    hb_r  <= b_b - b_t;
    ov1_r <= (x2 > x1) && (y2 > y1);
    // stage 2: areas
    inter2_r <= PW'(iw_r) * PW'(ih_r);
    aa2_r    <= PW'(wa_r) * PW'(ha_r);
    ab2_r    <= PW'(wb_r) * PW'(hb_r);
    ov2_r    <= ov1_r;
    // stage 3: union
    uni3_r   <= (PW + 1)'(aa2_r) + (PW + 1)'(ab2_r) - (PW + 1)'(inter2_r);
    inter3_r <= inter2_r;
    ov3_r    <= ov2_r;
    // stage 4: scale both sides
    lhs4_r <= {inter3_r, 16'd0};
    rhs4_r <= (PW + 17)'(thresh) * (PW + 17)'(uni3_r);
    ov4_r  <= ov3_r && (uni3_r != '0);
    // stage 5: compare
    hit_r  <= ov4_r && ((PW + 17)'(lhs4_r) > rhs4_r);
  end

  assign hit_v = v5_r;
  assign hit   = hit_r;

endmodule

>>> sv/per_class_box_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_suppression
// Greedy per-class NMS over a stored frame of candidate boxes.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in_      input      start & !busy           box corners, score, class, last
// out_     output     out_valid strobe        rank, box, score, class, flags
// cfg_     input      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Candidates load at one per cycle while busy is low; the last one raises busy.
// Each ranking pass reads the score memory once over the n stored candidates.
// The MAX_OUT ring cells then rotate past each ranked box in the overlap unit.
// Results cannot be stalled; the last is flagged from the finish state.
// Synchronous active-low reset; no memory clearing pass.
// ----------------------------------------------------------------------------
module per_class_box_suppression #(
  parameter int STORE_DEPTH = pcbs_pkg::STORE_DEPTH_DEF,
  parameter int MAX_OUT     = pcbs_pkg::MAX_OUT_DEF,
  parameter int COORD_BITS  = pcbs_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_box_left,
  input  logic [15:0] in_box_top,
  input  logic [15:0] in_box_right,
  input  logic [15:0] in_box_bottom,
  input  logic [15:0] in_score,
  input  logic [7:0]  in_class_index,
  input  logic        in_last_candidate,
  output logic        out_valid,
  output logic [5:0]  out_rank,
  output logic [15:0] out_left,
  output logic [15:0] out_top,
  output logic [15:0] out_right,
  output logic [15:0] out_bottom,
  output logic [15:0] out_score,
  output logic [7:0]  out_class,
  output logic        out_capacity_overflow,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "per_class_box_suppression_defines.svh"

  localparam int CB  = COORD_BITS;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int NW  = $clog2(STORE_DEPTH + 1);
  localparam int SW  = $clog2(STORE_DEPTH + 2);
  localparam int KW  = $clog2(MAX_OUT + 1);
  localparam int LAT = pcbs_pkg::IOU_LAT;
  localparam int CKW = $clog2(MAX_OUT + LAT + 1);
  localparam int BW  = 4 * CB;
  localparam int DW  = BW + 8;
  localparam int KEYW = 16 + AW;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_CHECK, S_DECIDE, S_FINISH
  } state_t;

  state_t state_r;

  // frame store
  logic [BW-1:0] corner_mem [STORE_DEPTH];
  logic [15:0]   score_mem  [STORE_DEPTH];
  logic [7:0]    class_mem  [STORE_DEPTH];

  logic [NW-1:0]   cnt_r;
  logic            ovf_r;
  logic [15:0]     thresh_r;
  logic [6:0]      max_kept_r;
  logic [6:0]      limit;

  logic [SW-1:0]   scan_a_r;
  logic            rd_v_r;
  logic [AW-1:0]   rd_idx_r;
  logic [15:0]     score_q;
  logic [BW-1:0]   cand_box_q;
  logic [7:0]      cand_cls_q;
  logic [KEYW-1:0] best_r, prev_r, rd_key;
  logic            found_r, first_r;
  logic            scan_done;
  logic [AW-1:0]   rd_addr;

  logic [CKW-1:0]  ck_r;
  logic            supp_r;
  logic [KW-1:0]   kept_r;

  logic            pend_v_r;
  logic [5:0]      pend_rank_r;
  logic [BW-1:0]   pend_box_r;
  logic [15:0]     pend_score_r;
  logic [7:0]      pend_cls_r;

  logic            out_valid_r, out_last_r, out_ovf_r;
  logic [5:0]      out_rank_r;
  logic [BW-1:0]   out_box_r;
  logic [15:0]     out_score_r;
  logic [7:0]      out_cls_r;

  logic [CB-1:0]   in_l, in_t, in_r, in_b;
  logic            accept;

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign in_l = CB'(in_box_left);
  assign in_t = CB'(in_box_top);
  assign in_r = CB'(in_box_right);
  assign in_b = CB'(in_box_bottom);

  assign limit = (max_kept_r == 7'd0) ? 7'd1 :
                 (max_kept_r > 7'(MAX_OUT)) ? 7'(MAX_OUT) : max_kept_r;

  assign scan_done = (scan_a_r == SW'(cnt_r) + SW'(1));
  assign rd_addr   = scan_done ? ~best_r[AW-1:0] : scan_a_r[AW-1:0];
  assign rd_key    = {score_q, ~rd_idx_r};

  always_ff @(posedge clk) begin
    if (accept && (cnt_r < NW'(STORE_DEPTH))) begin
      corner_mem[cnt_r[AW-1:0]] <= {in_l, in_t, in_r, in_b};
      score_mem[cnt_r[AW-1:0]]  <= in_score;
      class_mem[cnt_r[AW-1:0]]  <= in_class_index;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      score_q    <= score_mem[rd_addr];
      cand_box_q <= corner_mem[rd_addr];
      cand_cls_q <= class_mem[rd_addr];
    end
  end

  // kept-box ring
  pcbs_pkg::ring_ctrl_t ring_ctrl;
  logic          cell_v [MAX_OUT];
  logic [DW-1:0] cell_d [MAX_OUT];
  logic          insert;

  assign insert         = (state_r == S_DECIDE) && !supp_r;
  assign ring_ctrl.clr   = (state_r == S_FINISH);
  assign ring_ctrl.shift = ((state_r == S_CHECK) && (ck_r < CKW'(MAX_OUT))) || insert;

  for (genvar g = 0; g < MAX_OUT; g++) begin : g_cell
    logic          nb_v;
    logic [DW-1:0] nb_d;
    if (g == MAX_OUT - 1) begin : g_tail
      assign nb_v = insert ? 1'b1 : cell_v[0];
      assign nb_d = insert ? {cand_cls_q, cand_box_q} : cell_d[0];
    end else begin : g_body
      assign nb_v = cell_v[g + 1];
      assign nb_d = cell_d[g + 1];
    end
    pcbs_cell #(.W(DW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ring_ctrl),
      .nb_valid (nb_v),
      .nb_data  (nb_d),
      .valid    (cell_v[g]),
      .data     (cell_d[g])
    );
  end

  logic iou_in_v, hit_v, hit;
  assign iou_in_v = (state_r == S_CHECK) && (ck_r < CKW'(MAX_OUT)) && cell_v[0] &&
                    (cell_d[0][DW-1:BW] == cand_cls_q);

  pcbs_iou #(.CB(CB)) u_iou (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (iou_in_v),
    .a_l    (cell_d[0][4*CB-1:3*CB]),
    .a_t    (cell_d[0][3*CB-1:2*CB]),
    .a_r    (cell_d[0][2*CB-1:CB]),
    .a_b    (cell_d[0][CB-1:0]),
    .b_l    (cand_box_q[4*CB-1:3*CB]),
    .b_t    (cand_box_q[3*CB-1:2*CB]),
    .b_r    (cand_box_q[2*CB-1:CB]),
    .b_b    (cand_box_q[CB-1:0]),
    .thresh (thresh_r),
    .hit_v  (hit_v),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      thresh_r    <= pcbs_pkg::THRESH_RST;
      max_kept_r  <= pcbs_pkg::MAX_KEPT_RST;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      kept_r      <= '0;
      scan_a_r    <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      first_r     <= 1'b1;
      ck_r        <= '0;
      supp_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pcbs_pkg::CFG_THRESHOLD) begin
          thresh_r <= cfg_data;
        end else if (cfg_index == pcbs_pkg::CFG_MAX_KEPT) begin
          max_kept_r <= cfg_data[6:0];
        end
      end
      unique case (state_r)
        S_LOAD: begin
          if (start) begin
            if (cnt_r < NW'(STORE_DEPTH)) begin
              cnt_r <= cnt_r + NW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_candidate) begin
              state_r  <= S_SCAN;
              scan_a_r <= '0;
              rd_v_r   <= 1'b0;
              found_r  <= 1'b0;
              first_r  <= 1'b1;
              kept_r   <= '0;
              pend_v_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // next pick: highest {score, arrival-inverted index} below the last pick
          if (rd_v_r && (first_r || (rd_key < prev_r)) &&
              (!found_r || (rd_key > best_r))) begin
            best_r  <= rd_key;
            found_r <= 1'b1;
          end
          if (!scan_done) begin
            scan_a_r <= scan_a_r + SW'(1);
            rd_v_r   <= (scan_a_r < SW'(cnt_r));
            rd_idx_r <= scan_a_r[AW-1:0];
          end else if (found_r) begin
            prev_r  <= best_r;
            first_r <= 1'b0;
            ck_r    <= '0;
            supp_r  <= 1'b0;
            state_r <= S_CHECK;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_CHECK: begin
          ck_r <= ck_r + CKW'(1);
          if (hit_v && hit) begin
            supp_r <= 1'b1;
          end
          if (ck_r == CKW'(MAX_OUT + LAT)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          scan_a_r <= '0;
          rd_v_r   <= 1'b0;
          found_r  <= 1'b0;
          state_r  <= S_SCAN;
          if (!supp_r) begin
            if (pend_v_r) begin
              out_valid_r <= 1'b1;
              out_last_r  <= 1'b0;
              out_ovf_r   <= ovf_r;
              out_rank_r  <= pend_rank_r;
              out_box_r   <= pend_box_r;
              out_score_r <= pend_score_r;
              out_cls_r   <= pend_cls_r;
            end
            pend_v_r     <= 1'b1;
            pend_rank_r  <= 6'(kept_r);
            pend_box_r   <= cand_box_q;
            pend_score_r <= score_q;
            pend_cls_r   <= cand_cls_q;
            kept_r       <= kept_r + KW'(1);
            if ((7'(kept_r) + 7'd1) >= limit) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          out_valid_r <= pend_v_r;
          out_last_r  <= 1'b1;
          out_ovf_r   <= ovf_r;
          out_rank_r  <= pend_rank_r;
          out_box_r   <= pend_box_r;
          out_score_r <= pend_score_r;
          out_cls_r   <= pend_cls_r;
          pend_v_r    <= 1'b0;
          cnt_r       <= '0;
          ovf_r       <= 1'b0;
          state_r     <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_rank              = out_rank_r;
  assign out_left              = 16'(out_box_r[4*CB-1:3*CB]);
  assign out_top               = 16'(out_box_r[3*CB-1:2*CB]);
  assign out_right             = 16'(out_box_r[2*CB-1:CB]);
  assign out_bottom            = 16'(out_box_r[CB-1:0]);
  assign out_score             = out_score_r;
  assign out_class             = out_cls_r;
  assign out_capacity_overflow = out_ovf_r;
  assign out_last_result       = out_last_r;

  `PCBS_ASSERT_NXT(a_last_ends_frame, out_valid && out_last_result, !out_valid)
  `PCBS_ASSERT_NXT(a_last_goes_busy, accept && in_last_candidate, busy)
  `PCBS_ASSERT_NXT(a_full_flags, accept && (cnt_r == NW'(STORE_DEPTH)), ovf_r)
  `PCBS_ASSERT_IMP(a_no_insert_past_limit, insert, 7'(kept_r) < limit)

endmodule
